/* rtl/trp_pkg.sv */
// Shared types, constants and the status map of the ranging result processor.
// Used by every module of the block but trp_checker; depends on nothing.
`default_nettype none

package trp_pkg;

  // Range scaling: (range * 2011 + 0x400) >> 11
  localparam int unsigned RangeMulW = 11;
  localparam logic [RangeMulW-1:0] RANGE_MUL = 11'd2011;
  localparam int unsigned RangeProdW = 27;
  localparam logic [RangeProdW-1:0] RANGE_ROUND = 27'h400;
  localparam int unsigned RangeShift = 11;

  localparam logic [15:0] SAT16        = 16'hFFFF;
  localparam logic [15:0] SPAD_DEFAULT = 16'h8000;
  localparam logic [15:0] TARGET_RESET = 16'h0A00;

  // Raw device status bytes
  localparam logic [7:0] RAW_HW_FAIL_A = 8'd1;
  localparam logic [7:0] RAW_HW_FAIL_B = 8'd2;
  localparam logic [7:0] RAW_HW_FAIL_C = 8'd3;
  localparam logic [7:0] RAW_SIGNAL    = 8'd4;
  localparam logic [7:0] RAW_BOUNDS    = 8'd5;
  localparam logic [7:0] RAW_SIGMA     = 8'd6;
  localparam logic [7:0] RAW_WRAP      = 8'd7;
  localparam logic [7:0] RAW_CLIPPED   = 8'd8;
  localparam logic [7:0] RAW_RANGE_OK  = 8'd9;
  localparam logic [7:0] RAW_XTALK     = 8'd12;
  localparam logic [7:0] RAW_MIN_RANGE = 8'd13;
  localparam logic [7:0] RAW_HW_FAIL_D = 8'd17;
  localparam logic [7:0] RAW_SYNC      = 8'd18;

  typedef enum logic [3:0] {
    ST_VALID     = 4'd0,
    ST_HW_FAIL   = 4'd1,
    ST_MIN_RANGE = 4'd2,
    ST_SYNC      = 4'd3,
    ST_BOUNDS    = 4'd4,
    ST_SIGNAL    = 4'd5,
    ST_SIGMA     = 4'd6,
    ST_WRAP      = 4'd7,
    ST_XTALK     = 4'd8,
    ST_CLIPPED   = 4'd9,
    ST_NO_WRAP   = 4'd10,
    ST_NONE      = 4'd11
  } status_e;

  // Back end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV_RATE,
    BK_DIV_SEL,
    BK_HOLD
  } back_state_e;

  // One classified transaction waiting for the back end
  typedef struct packed {
    logic [15:0] dist_mm;
    status_e     status_code;
    logic [15:0] spads;
    logic [15:0] total_rate;
  } trp_entry_t;

  // Divider request and response
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } trp_div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } trp_div_rsp_t;

  // Map the raw status byte onto the dense status code
  function automatic status_e map_status(logic [7:0] raw, logic [7:0] stream);
    status_e code;
    unique case (raw)
      RAW_HW_FAIL_A, RAW_HW_FAIL_B, RAW_HW_FAIL_C, RAW_HW_FAIL_D: code = ST_HW_FAIL;
      RAW_MIN_RANGE: code = ST_MIN_RANGE;
      RAW_SYNC:      code = ST_SYNC;
      RAW_BOUNDS:    code = ST_BOUNDS;
      RAW_SIGNAL:    code = ST_SIGNAL;
      RAW_SIGMA:     code = ST_SIGMA;
      RAW_WRAP:      code = ST_WRAP;
      RAW_XTALK:     code = ST_XTALK;
      RAW_CLIPPED:   code = ST_CLIPPED;
      RAW_RANGE_OK:  code = (stream == 8'd0) ? ST_NO_WRAP : ST_VALID;
      default:       code = ST_NONE;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

/* rtl/trp_front.sv */
// Front end: classifies an incoming ranging transaction into a queue entry.
// Scales the range, maps the status and saturates the total rate; uses trp_pkg.
`default_nettype none

module trp_front (
  input  logic [7:0]          raw_status_i,
  input  logic [7:0]          stream_cnt_i,
  input  logic [15:0]         effective_spads_i,
  input  logic [15:0]         ambient_rate_i,
  input  logic [15:0]         signal_rate_i,
  input  logic [15:0]         raw_range_i,
  output trp_pkg::trp_entry_t entry_o
);
  import trp_pkg::*;

  logic [RangeProdW-1:0] range_prod;
  logic [16:0]           rate_sum;

  // Scale the range with rounding
  assign range_prod = RangeProdW'(raw_range_i) * RangeProdW'(RANGE_MUL) + RANGE_ROUND;

  // Sum the rates
  assign rate_sum = {1'b0, signal_rate_i} + {1'b0, ambient_rate_i};

  always_comb begin
    entry_o.dist_mm     = range_prod[RangeShift +: 16];
    entry_o.status_code = map_status(raw_status_i, stream_cnt_i);
    entry_o.spads       = effective_spads_i;
    // Saturate the total rate to 16 bits
    entry_o.total_rate  = rate_sum[16] ? SAT16 : rate_sum[15:0];
  end

endmodule

`default_nettype wire

/* rtl/trp_fifo.sv */
// Short queue between the front and back ends of the ranging result processor.
// Holds classified entries; uses trp_pkg for the entry type.
`default_nettype none

module trp_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  trp_pkg::trp_entry_t push_data_i,
  input  logic                pop_i,
  output trp_pkg::trp_entry_t pop_data_o,
  output logic                full_o,
  output logic                empty_o
);
  import trp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  trp_entry_t          slot_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q;
  logic                do_push, do_pop;

  assign full_o     = (count_q == CntW'(Depth));
  assign empty_o    = (count_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = slot_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/trp_div.sv */
// Iterative unsigned 32 by 32 bit divider, four quotient bits per cycle.
// Restoring scheme; uses trp_pkg request types.
`default_nettype none

module trp_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  trp_pkg::trp_div_req_t req_i,
  output trp_pkg::trp_div_rsp_t rsp_o
);
  import trp_pkg::*;

  localparam int unsigned BitsPerCycle = 4;
  localparam int unsigned Steps        = 32 / BitsPerCycle;
  localparam int unsigned CntW         = $clog2(Steps);

  logic [32:0]     rem_q, rem_d;
  logic [31:0]     quo_q, quo_d;
  logic [31:0]     dsr_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;

  // Retire four restoring steps
  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    for (int i = 0; i < BitsPerCycle; i++) begin
      rem_d = {rem_d[31:0], quo_d[31]};
      quo_d = {quo_d[30:0], 1'b0};
      if (rem_d >= {1'b0, dsr_q}) begin
        rem_d    = rem_d - {1'b0, dsr_q};
        quo_d[0] = 1'b1;
      end
    end
  end

  // Sequence the iterations
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(Steps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Hold the working remainder and quotient
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

/* rtl/trp_back.sv */
// Back end: works out the SPAD select for each queued entry and drives the result.
// Sequences up to two divisions on trp_div and holds an output register; uses trp_pkg.
`default_nettype none

module trp_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [15:0]           target_rate_i,
  input  trp_pkg::trp_entry_t   entry_i,
  input  logic                  empty_i,
  output logic                  pop_o,
  output trp_pkg::trp_div_req_t div_req_o,
  input  trp_pkg::trp_div_rsp_t div_rsp_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [15:0]           dist_mm_o,
  output logic [3:0]            status_code_o,
  output logic [15:0]           spad_select_o
);
  import trp_pkg::*;

  back_state_e state_q, state_d;
  trp_entry_t  entry_q;
  logic [15:0] sel_q;
  logic        out_valid_q;
  logic [15:0] range_q;
  status_e     status_q;
  logic [15:0] spad_q;
  logic        out_free, load_out, rate_zero, spads_zero;

  assign out_free   = !out_valid_q || out_ready_i;
  assign rate_zero  = (div_rsp_i.quotient == '0);
  assign spads_zero = (entry_i.spads == '0);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!empty_i) state_d = spads_zero ? BK_HOLD : BK_DIV_RATE;
      end
      BK_DIV_RATE: begin
        if (div_rsp_i.done) state_d = rate_zero ? BK_HOLD : BK_DIV_SEL;
      end
      BK_DIV_SEL: begin
        if (div_rsp_i.done) state_d = BK_HOLD;
      end
      BK_HOLD: begin
        if (out_free) state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    pop_o              = 1'b0;
    load_out           = 1'b0;
    div_req_o.start    = 1'b0;
    div_req_o.dividend = {target_rate_i, 16'h0000};
    div_req_o.divisor  = div_rsp_i.quotient;
    unique case (state_q)
      BK_IDLE: begin
        pop_o              = !empty_i;
        div_req_o.start    = !empty_i && !spads_zero;
        div_req_o.dividend = {entry_i.total_rate, 16'h0000};
        div_req_o.divisor  = {16'h0000, entry_i.spads};
      end
      BK_DIV_RATE: begin
        div_req_o.start = div_rsp_i.done && !rate_zero;
      end
      BK_DIV_SEL: begin
      end
      BK_HOLD: begin
        load_out = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // Raise valid on load, drop it once the transaction is taken
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Latch the entry and the select; saturate the final quotient
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      entry_q <= entry_i;
      sel_q   <= SPAD_DEFAULT;
    end else if (state_q == BK_DIV_SEL && div_rsp_i.done) begin
      sel_q <= (div_rsp_i.quotient[31:16] != '0) ? SAT16 : div_rsp_i.quotient[15:0];
    end
    if (load_out) begin
      range_q  <= entry_q.dist_mm;
      status_q <= entry_q.status_code;
      spad_q   <= sel_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign dist_mm_o     = range_q;
  assign status_code_o = status_q;
  assign spad_select_o = spad_q;

endmodule

`default_nettype wire

/* rtl/tof_range_result_processor_unit.sv */
// Top level of the ranging result processor: target rate register and wiring
// of trp_front, trp_fifo, trp_div and trp_back; uses trp_pkg.
`default_nettype none

// Each accepted ranging transaction yields one result: the range scaled by
// 2011/2048 with rounding, a dense status code and the next manual SPAD
// select. The front end classifies a transaction in the cycle it is accepted
// and places it in a queue of QueueDepth entries; input ready is low only
// while that queue is full. The back end handles one transaction at a time
// with one shared divider that retires four quotient bits per cycle and runs
// up to twice per transaction: total rate by SPAD count, then target rate by
// that per-SPAD rate; it skips both when the SPAD count is zero and the second
// when the per-SPAD rate is zero. A finished result waits in an output register
// while the next transaction is already being worked on. The target rate
// register resets to 0x0A00 and is written through the cfg channel, which is
// always ready.
module tof_range_result_processor_unit #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  raw_status_i,
  input  logic [7:0]  stream_cnt_i,
  input  logic [15:0] effective_spads_i,
  input  logic [15:0] ambient_rate_i,
  input  logic [15:0] signal_rate_i,
  input  logic [15:0] raw_range_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] dist_mm_o,
  output logic [3:0]  status_code_o,
  output logic [15:0] spad_select_o
);
  import trp_pkg::*;

  logic [15:0]  target_rate_q;
  trp_entry_t   front_entry, queue_entry;
  logic         queue_full, queue_empty, queue_pop;
  trp_div_req_t div_req;
  trp_div_rsp_t div_rsp;

  // Hold the target rate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_rate_q <= TARGET_RESET;
    end else if (cfg_valid_i) begin
      target_rate_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !queue_full;

  trp_front u_front (
    .raw_status_i      (raw_status_i),
    .stream_cnt_i      (stream_cnt_i),
    .effective_spads_i (effective_spads_i),
    .ambient_rate_i    (ambient_rate_i),
    .signal_rate_i     (signal_rate_i),
    .raw_range_i       (raw_range_i),
    .entry_o           (front_entry)
  );

  trp_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_data_i (front_entry),
    .pop_i       (queue_pop),
    .pop_data_o  (queue_entry),
    .full_o      (queue_full),
    .empty_o     (queue_empty)
  );

  trp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  trp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .target_rate_i (target_rate_q),
    .entry_i       (queue_entry),
    .empty_i       (queue_empty),
    .pop_o         (queue_pop),
    .div_req_o     (div_req),
    .div_rsp_i     (div_rsp),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .dist_mm_o     (dist_mm_o),
    .status_code_o (status_code_o),
    .spad_select_o (spad_select_o)
  );

endmodule

`default_nettype wire

/* rtl/trp_checker.sv */
// Port-level checks for the ranging result processor, with the bind that
// attaches them to tof_range_result_processor_unit.
`default_nettype none

module trp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] dist_mm_o,
  input logic [3:0]  status_code_o,
  input logic [15:0] spad_select_o
);

  // No result shows while in reset
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

  // Hold a stalled result
  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before acceptance");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(dist_mm_o) && $stable(status_code_o) && $stable(spad_select_o))
    else $error("stalled result payload changed");

  // Status code stays within the map
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_code_o <= 4'd11)
    else $error("status code out of range");

  // Scaled range cannot exceed the full-scale value
  a_range_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> dist_mm_o <= 16'd64351)
    else $error("scaled range out of range");

endmodule

bind tof_range_result_processor_unit trp_checker u_trp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .dist_mm_o     (dist_mm_o),
  .status_code_o (status_code_o),
  .spad_select_o (spad_select_o)
);

`default_nettype wire
